@@ hdl/mfat_pkg.sv @@
// ----------------------------------------------------------------------------
// mfat_pkg
// Shared types and constants of the motor feedback angle tracker.
// ----------------------------------------------------------------------------
package mfat_pkg;

  // slot layout: chassis slots, launcher slots, then feeder, pitch and yaw
  localparam int CHASSIS_MOTORS  = 4;
  localparam int LAUNCHER_MOTORS = 2;
  localparam int FEEDER_SLOT     = CHASSIS_MOTORS + LAUNCHER_MOTORS;
  localparam int PITCH_SLOT      = FEEDER_SLOT + 1;
  localparam int YAW_SLOT        = FEEDER_SLOT + 2;
  localparam int NUM_SLOTS       = FEEDER_SLOT + 3;
  localparam int SLOT_W          = $clog2(NUM_SLOTS);
  localparam int SLOT_OUT_W      = 4;

  localparam int ID_W     = 11;
  localparam int ANGLE_W  = 16;
  localparam int WORD_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 8;
  localparam int TOTAL_W  = 32;

  localparam int HALF_TURN  = 4096;
  localparam int TURN_SHIFT = 13;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CHASSIS_BASE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LAUNCHER_BASE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FEEDER_ID     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_ID      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_YAW_ID        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CAL_FRAMES    = 3'd5;

  localparam logic [ID_W-1:0]  RST_CHASSIS_BASE  = 11'd513;
  localparam logic [ID_W-1:0]  RST_LAUNCHER_BASE = 11'd517;
  localparam logic [ID_W-1:0]  RST_FEEDER_ID     = 11'd519;
  localparam logic [ID_W-1:0]  RST_PITCH_ID      = 11'd522;
  localparam logic [ID_W-1:0]  RST_YAW_ID        = 11'd521;
  localparam logic [CNT_W-1:0] RST_CAL_FRAMES    = 8'd50;

  typedef struct packed {
    logic [ID_W-1:0]  chassis_base_id;
    logic [ID_W-1:0]  launcher_base_id;
    logic [ID_W-1:0]  feeder_id;
    logic [ID_W-1:0]  pitch_id;
    logic [ID_W-1:0]  yaw_id;
    logic [CNT_W-1:0] calibration_frames;
  } cfg_t;

  // one slot record as held in the slot memory
  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] offset;
    logic [TOTAL_W-1:0] turns;
    logic [CNT_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
    logic [WORD_W-1:0]  speed;
    logic [WORD_W-1:0]  torque;
    logic [WORD_W-1:0]  given;
    logic [BYTE_W-1:0]  temp;
  } rec_t;

endpackage

@@ hdl/motor_feedback_angle_tracker.sv @@
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker
// Tracks multi-turn encoder angle and feedback words per motor slot.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid_i / in_ready_o, frame  | sink
//  out     | out_valid_o / out_ready_i, rec  | source
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i | sink
//
// one item per cycle while the output is not stalled; a matched item is read
// from slot memory into the update stage, then updated, written back and output
// slot records sit in a 9-entry memory with a registered read port; a
// per-slot valid bit cleared by reset makes unwritten slots read as zero
// back-to-back items on one slot are served by forwarding the last write
// a stalled output holds the update stage, which then holds the input
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker import mfat_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ID_W-1:0]             cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ID_W-1:0]             frame_id_i,
  input  logic [ANGLE_W-1:0]          angle_word_i,
  input  logic signed [WORD_W-1:0]    second_word_i,
  input  logic signed [WORD_W-1:0]    third_word_i,
  input  logic [BYTE_W-1:0]           sixth_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [SLOT_OUT_W-1:0]       slot_o,
  output logic                        calibrating_o,
  output logic [ANGLE_W-1:0]          angle_o,
  output logic signed [TOTAL_W-1:0]   total_angle_o,
  output logic signed [WORD_W-1:0]    speed_rpm_o,
  output logic signed [WORD_W-1:0]    torque_current_o,
  output logic signed [WORD_W-1:0]    given_current_o,
  output logic [BYTE_W-1:0]           temperature_o
);

  localparam logic signed [ANGLE_W:0] HALF_POS = (ANGLE_W+1)'(HALF_TURN);
  localparam logic signed [ANGLE_W:0] HALF_NEG = -HALF_POS;

  cfg_t cfg_q;

  logic              hit;
  logic [SLOT_W-1:0] match_slot;
  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic              s1_adv;

  // update stage
  logic               s1_valid_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [ANGLE_W-1:0] s1_angle_q;
  logic [WORD_W-1:0]  s1_w2_q;
  logic [WORD_W-1:0]  s1_w3_q;
  logic [BYTE_W-1:0]  s1_b6_q;

  // slot memory and its helpers
  rec_t                 slot_mem_q [NUM_SLOTS];
  rec_t                 rd_rec_q;
  logic                 rd_ok_q;
  logic [NUM_SLOTS-1:0] slot_ok_q;
  logic                 fwd_vld_q;
  logic [SLOT_W-1:0]    fwd_slot_q;
  rec_t                 fwd_rec_q;

  rec_t                 cur_rec;
  rec_t                 nxt_rec;
  logic                 calib;
  logic signed [ANGLE_W:0] diff;
  logic [TOTAL_W-1:0]   turns_d;

  // output register
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_calib_q;
  rec_t              out_rec_q;

  mfat_match u_match (
    .cfg_i      (cfg_q),
    .frame_id_i (frame_id_i),
    .hit_o      (hit),
    .slot_o     (match_slot)
  );

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;
  assign rd_en      = accept && hit;
  assign wr_en      = s1_valid_q && s1_adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chassis_base_id    <= RST_CHASSIS_BASE;
      cfg_q.launcher_base_id   <= RST_LAUNCHER_BASE;
      cfg_q.feeder_id          <= RST_FEEDER_ID;
      cfg_q.pitch_id           <= RST_PITCH_ID;
      cfg_q.yaw_id             <= RST_YAW_ID;
      cfg_q.calibration_frames <= RST_CAL_FRAMES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHASSIS_BASE:  cfg_q.chassis_base_id    <= cfg_data_i;
        REG_LAUNCHER_BASE: cfg_q.launcher_base_id   <= cfg_data_i;
        REG_FEEDER_ID:     cfg_q.feeder_id          <= cfg_data_i;
        REG_PITCH_ID:      cfg_q.pitch_id           <= cfg_data_i;
        REG_YAW_ID:        cfg_q.yaw_id             <= cfg_data_i;
        REG_CAL_FRAMES:    cfg_q.calibration_frames <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // slot memory: one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[s1_slot_q] <= nxt_rec;
    end
    if (rd_en) begin
      rd_rec_q <= slot_mem_q[match_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_ok_q <= '0;
      rd_ok_q   <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_ok_q <= slot_ok_q[match_slot];
      end
      if (wr_en) begin
        slot_ok_q[s1_slot_q] <= 1'b1;
        fwd_vld_q            <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_slot_q <= s1_slot_q;
      fwd_rec_q  <= nxt_rec;
    end
    if (rd_en) begin
      s1_slot_q  <= match_slot;
      s1_angle_q <= angle_word_i;
      s1_w2_q    <= second_word_i;
      s1_w3_q    <= third_word_i;
      s1_b6_q    <= sixth_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rd_en) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // the latest write is never older than memory contents, so it wins whenever it is for the same slot
  always_comb begin
    if (fwd_vld_q && (fwd_slot_q == s1_slot_q)) begin
      cur_rec = fwd_rec_q;
    end else if (rd_ok_q) begin
      cur_rec = rd_rec_q;
    end else begin
      cur_rec = '0;
    end
  end

  assign calib = cur_rec.count <= cfg_q.calibration_frames;
  assign diff  = $signed({1'b0, s1_angle_q}) - $signed({1'b0, cur_rec.angle});

  always_comb begin
    priority if (diff > HALF_POS) begin
      turns_d = cur_rec.turns - TOTAL_W'(1);
    end else if (diff < HALF_NEG) begin
      turns_d = cur_rec.turns + TOTAL_W'(1);
    end else begin
      turns_d = cur_rec.turns;
    end
  end

  always_comb begin
    nxt_rec       = cur_rec;
    nxt_rec.angle = s1_angle_q;
    if (cur_rec.count != '1) begin
      nxt_rec.count = cur_rec.count + CNT_W'(1);
    end
    if (calib) begin
      nxt_rec.offset = s1_angle_q;
    end else begin
      nxt_rec.turns = turns_d;
      nxt_rec.total = {turns_d[TOTAL_W-TURN_SHIFT-1:0], {TURN_SHIFT{1'b0}}}
                      + TOTAL_W'(s1_angle_q) - TOTAL_W'(cur_rec.offset);
      // motor-type slots up to the feeder, gimbal slots after it
      if (s1_slot_q <= SLOT_W'(FEEDER_SLOT)) begin
        nxt_rec.speed  = s1_w2_q;
        nxt_rec.torque = s1_w3_q;
        nxt_rec.temp   = s1_b6_q;
        nxt_rec.given  = '0;
      end else begin
        nxt_rec.torque = s1_w2_q;
        nxt_rec.given  = s1_w3_q;
        nxt_rec.speed  = '0;
        nxt_rec.temp   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_slot_q  <= s1_slot_q;
      out_calib_q <= calib;
      out_rec_q   <= nxt_rec;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign slot_o           = SLOT_OUT_W'(out_slot_q);
  assign calibrating_o    = out_calib_q;
  assign angle_o          = out_rec_q.angle;
  assign total_angle_o    = out_rec_q.total;
  assign speed_rpm_o      = out_rec_q.speed;
  assign torque_current_o = out_rec_q.torque;
  assign given_current_o  = out_rec_q.given;
  assign temperature_o    = out_rec_q.temp;

`ifndef NO_ASSERTIONS
  a_match_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && hit) |=> s1_valid_q)
    else $error("matched item did not enter the update stage");

  a_stage_holds_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_slot_q)))
    else $error("stalled update stage lost its item");

  a_out_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_slot_q < SLOT_W'(NUM_SLOTS)))
    else $error("result slot out of range");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after being taken");

  a_written_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (slot_ok_q[fwd_slot_q] && fwd_vld_q))
    else $error("written slot not marked valid");
`endif

endmodule

@@ hdl/mfat_match.sv @@
// ----------------------------------------------------------------------------
// mfat_match
// Maps a frame identifier onto a motor slot, first match wins.
// ----------------------------------------------------------------------------
module mfat_match import mfat_pkg::*; (
  input  cfg_t              cfg_i,
  input  logic [ID_W-1:0]   frame_id_i,
  output logic              hit_o,
  output logic [SLOT_W-1:0] slot_o
);

  logic [ID_W-1:0] chassis_d;
  logic [ID_W-1:0] launcher_d;

  // offsets from the base identifiers, wrapping at 11 bits
  assign chassis_d  = frame_id_i - cfg_i.chassis_base_id;
  assign launcher_d = frame_id_i - cfg_i.launcher_base_id;

  always_comb begin
    hit_o  = 1'b1;
    slot_o = '0;
    priority if (chassis_d < ID_W'(CHASSIS_MOTORS)) begin
      slot_o = SLOT_W'(chassis_d);
    end else if (launcher_d < ID_W'(LAUNCHER_MOTORS)) begin
      slot_o = SLOT_W'(CHASSIS_MOTORS) + SLOT_W'(launcher_d);
    end else if (frame_id_i == cfg_i.feeder_id) begin
      slot_o = SLOT_W'(FEEDER_SLOT);
    end else if (frame_id_i == cfg_i.pitch_id) begin
      slot_o = SLOT_W'(PITCH_SLOT);
    end else if (frame_id_i == cfg_i.yaw_id) begin
      slot_o = SLOT_W'(YAW_SLOT);
    end else begin
      hit_o = 1'b0;
    end
  end

endmodule

@@ verif/motor_feedback_angle_tracker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_angle_tracker_test
// Self-checking bench for the motor feedback angle tracker. A scoreboard
// class keeps its own copy of the id registers and of every slot record. It
// works out the record that each accepted frame should produce, and it
// compares the records leaving the block in order, field by field. Frames
// come as two short directed sets, then as random phases with different id
// layouts and calibration lengths. Both sides of the block pause at random.
// ----------------------------------------------------------------------------
module motor_feedback_angle_tracker_test;
  import mfat_pkg::*;

  localparam int SETTLE = 4;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ANGLE_W-1:0] angle;
    logic [WORD_W-1:0]  second_word;
    logic [WORD_W-1:0]  third_word;
    logic [BYTE_W-1:0]  sixth_byte;
  } frame_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  calibrating;
    logic [ANGLE_W-1:0]    angle;
    logic [TOTAL_W-1:0]    total_angle;
    logic [WORD_W-1:0]     speed_rpm;
    logic [WORD_W-1:0]     torque_current;
    logic [WORD_W-1:0]     given_current;
    logic [BYTE_W-1:0]     temperature;
  } slot_report_t;

  class slot_record_board;
    cfg_t         regs;
    rec_t         slots [NUM_SLOTS];
    slot_report_t due_reports [$];
    int           errors;

    function new();
      regs.chassis_base_id    = RST_CHASSIS_BASE;
      regs.launcher_base_id   = RST_LAUNCHER_BASE;
      regs.feeder_id          = RST_FEEDER_ID;
      regs.pitch_id           = RST_PITCH_ID;
      regs.yaw_id             = RST_YAW_ID;
      regs.calibration_frames = RST_CAL_FRAMES;
      foreach (slots[s]) slots[s] = '0;
      errors = 0;
    endfunction

    function void write_reg(input logic [REG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
      case (idx)
        REG_CHASSIS_BASE:  regs.chassis_base_id    = data;
        REG_LAUNCHER_BASE: regs.launcher_base_id   = data;
        REG_FEEDER_ID:     regs.feeder_id          = data;
        REG_PITCH_ID:      regs.pitch_id           = data;
        REG_YAW_ID:        regs.yaw_id             = data;
        REG_CAL_FRAMES:    regs.calibration_frames = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // first match wins: chassis, launcher, feeder, pitch, yaw
    function int find_slot(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] d;
      d = id - regs.chassis_base_id;
      if (d < CHASSIS_MOTORS) return int'(d);
      d = id - regs.launcher_base_id;
      if (d < LAUNCHER_MOTORS) return CHASSIS_MOTORS + int'(d);
      if (id == regs.feeder_id) return FEEDER_SLOT;
      if (id == regs.pitch_id) return PITCH_SLOT;
      if (id == regs.yaw_id) return YAW_SLOT;
      return -1;
    endfunction

    function void take_frame(input frame_t f);
      int           s;
      int           diff;
      logic         calib;
      rec_t         r;
      slot_report_t rep;
      s = find_slot(f.id);
      if (s < 0) return;
      r = slots[s];
      calib = (r.count <= regs.calibration_frames);
      if (r.count != '1) r.count++;
      if (calib) begin
        r.angle  = f.angle;
        r.offset = f.angle;
      end else begin
        // a jump of more than half a turn means the encoder wrapped
        diff = int'(f.angle) - int'(r.angle);
        if (diff > HALF_TURN) r.turns -= 1;
        else if (diff < -HALF_TURN) r.turns += 1;
        r.angle = f.angle;
        r.total = (r.turns << TURN_SHIFT) + TOTAL_W'(f.angle) - TOTAL_W'(r.offset);
        if (s <= FEEDER_SLOT) begin
          r.speed  = f.second_word;
          r.torque = f.third_word;
          r.temp   = f.sixth_byte;
          r.given  = '0;
        end else begin
          r.torque = f.second_word;
          r.given  = f.third_word;
          r.speed  = '0;
          r.temp   = '0;
        end
      end
      slots[s] = r;
      rep = '{s[SLOT_OUT_W-1:0], calib, r.angle, r.total, r.speed, r.torque, r.given, r.temp};
      due_reports.push_back(rep);
    endfunction

    function void check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void compare_report(input slot_report_t got);
      slot_report_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: record for slot %0d with no frame pending", $time, got.slot);
        errors++;
        return;
      end
      want = due_reports.pop_front();
      check_field("slot", 32'(want.slot), 32'(got.slot));
      check_field("calibrating", 32'(want.calibrating), 32'(got.calibrating));
      check_field("angle", 32'(want.angle), 32'(got.angle));
      check_field("total_angle", want.total_angle, got.total_angle);
      check_field("speed_rpm", 32'(want.speed_rpm), 32'(got.speed_rpm));
      check_field("torque_current", 32'(want.torque_current), 32'(got.torque_current));
      check_field("given_current", 32'(want.given_current), 32'(got.given_current));
      check_field("temperature", 32'(want.temperature), 32'(got.temperature));
    endfunction
  endclass

  slot_record_board sb = new();

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [REG_IDX_W-1:0]      cfg_idx_i;
  logic [ID_W-1:0]           cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [ID_W-1:0]           frame_id_i;
  logic [ANGLE_W-1:0]        angle_word_i;
  logic signed [WORD_W-1:0]  second_word_i;
  logic signed [WORD_W-1:0]  third_word_i;
  logic [BYTE_W-1:0]         sixth_byte_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [SLOT_OUT_W-1:0]     slot_o;
  logic                      calibrating_o;
  logic [ANGLE_W-1:0]        angle_o;
  logic signed [TOTAL_W-1:0] total_angle_o;
  logic signed [WORD_W-1:0]  speed_rpm_o;
  logic signed [WORD_W-1:0]  torque_current_o;
  logic signed [WORD_W-1:0]  given_current_o;
  logic [BYTE_W-1:0]         temperature_o;

  bit                 calm = 1'b1;
  int unsigned        ready_hold = 0;
  logic [ANGLE_W-1:0] last_ang [NUM_SLOTS];
  slot_report_t       seen_rec;

  motor_feedback_angle_tracker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_id_i       (frame_id_i),
    .angle_word_i     (angle_word_i),
    .second_word_i    (second_word_i),
    .third_word_i     (third_word_i),
    .sixth_byte_i     (sixth_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .slot_o           (slot_o),
    .calibrating_o    (calibrating_o),
    .angle_o          (angle_o),
    .total_angle_o    (total_angle_o),
    .speed_rpm_o      (speed_rpm_o),
    .torque_current_o (torque_current_o),
    .given_current_o  (given_current_o),
    .temperature_o    (temperature_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_W-1:0] id_for_slot(input int s);
    if (s < CHASSIS_MOTORS) return sb.regs.chassis_base_id + ID_W'(s);
    if (s < FEEDER_SLOT) return sb.regs.launcher_base_id + ID_W'(s - CHASSIS_MOTORS);
    if (s == FEEDER_SLOT) return sb.regs.feeder_id;
    if (s == PITCH_SLOT) return sb.regs.pitch_id;
    return sb.regs.yaw_id;
  endfunction

  // small moves, half-turn jumps around the unwrap threshold and wraps
  function automatic logic [ANGLE_W-1:0] next_angle(input logic [ANGLE_W-1:0] prev);
    logic [ANGLE_W-1:0] step;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: step = ANGLE_W'($urandom_range(0, 600) - 300);
      5, 6:          step = ANGLE_W'($urandom_range(4000, 4200));
      7:             step = $urandom_range(0, 1) ? 16'd4096 : 16'd4097;
      8:             step = ANGLE_W'($urandom);
      default:       step = ANGLE_W'($urandom_range(60000, 65535));
    endcase
    if ($urandom_range(0, 1)) step = -step;
    return prev + step;
  endfunction

  function automatic frame_t make_frame(input int focus);
    frame_t f;
    int     s;
    if (focus >= 0 && $urandom_range(0, 9) != 0) s = focus;
    else s = $urandom_range(0, NUM_SLOTS - 1);
    f.id = id_for_slot(s);
    if ($urandom_range(0, 99) < 15) f.id = ID_W'($urandom_range(0, 2047));
    f.angle       = next_angle(last_ang[s]);
    last_ang[s]   = f.angle;
    f.second_word = WORD_W'($urandom);
    f.third_word  = WORD_W'($urandom);
    f.sixth_byte  = BYTE_W'($urandom);
    return f;
  endfunction

  function automatic cfg_t random_ids(input logic [CNT_W-1:0] cal);
    cfg_t c;
    c.chassis_base_id    = ID_W'($urandom_range(0, 2047));
    c.launcher_base_id   = ID_W'($urandom_range(0, 2047));
    c.feeder_id          = ID_W'($urandom_range(0, 2047));
    c.pitch_id           = ID_W'($urandom_range(0, 2047));
    c.yaw_id             = ID_W'($urandom_range(0, 2047));
    c.calibration_frames = cal;
    return c;
  endfunction

  task automatic send_frame(input frame_t f, input int unsigned gap);
    in_valid_i    <= 1'b1;
    frame_id_i    <= f.id;
    angle_word_i  <= f.angle;
    second_word_i <= f.second_word;
    third_word_i  <= f.third_word;
    sixth_byte_i  <= f.sixth_byte;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_frame(f);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // unmatched frames leave nothing pending and never enter the update stage
  task automatic drain(input int settle);
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c);
    logic [REG_IDX_W-1:0] idx [6];
    logic [ID_W-1:0]      val [6];
    idx = '{REG_CHASSIS_BASE, REG_LAUNCHER_BASE, REG_FEEDER_ID,
            REG_PITCH_ID, REG_YAW_ID, REG_CAL_FRAMES};
    val = '{c.chassis_base_id, c.launcher_base_id, c.feeder_id,
            c.pitch_id, c.yaw_id, ID_W'(c.calibration_frames)};
    foreach (idx[k]) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input cfg_t c, input int n, input int focus, input bit steady);
    drain(SETTLE);
    calm = steady;
    program_regs(c);
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) drain(0);
      send_frame(make_frame(focus), pick_gap());
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (calm) begin
        out_ready_i <= 1'b1;
      end else if (ready_hold != 0) begin
        ready_hold <= ready_hold - 1;
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
        ready_hold  <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_rec = '{slot_o, calibrating_o, angle_o, total_angle_o, speed_rpm_o,
                   torque_current_o, given_current_o, temperature_o};
      sb.compare_report(seen_rec);
    end
  end

  initial begin
    cfg_t c;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_CHASSIS_BASE;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    frame_id_i    <= '0;
    angle_word_i  <= '0;
    second_word_i <= '0;
    third_word_i  <= '0;
    sixth_byte_i  <= '0;
    out_ready_i   <= 1'b0;
    foreach (last_ang[s]) last_ang[s] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset id layout, every frame still calibrating
    calm = 1'b0;
    send_frame('{11'd513, 16'd0,     16'h8000, 16'h7FFF, 8'd255}, pick_gap());
    send_frame('{11'd514, 16'd65535, 16'h7FFF, 16'h8000, 8'd0},   pick_gap());
    send_frame('{11'd515, 16'd100,   16'h0001, 16'hFFFF, 8'd1},   pick_gap());
    send_frame('{11'd516, 16'd200,   16'h1234, 16'h4321, 8'd128}, pick_gap());
    send_frame('{11'd517, 16'd300,   16'hFFFF, 16'h0000, 8'd7},   pick_gap());
    send_frame('{11'd518, 16'd400,   16'h0000, 16'hFFFF, 8'd8},   pick_gap());
    send_frame('{11'd519, 16'd500,   16'h5555, 16'hAAAA, 8'd9},   pick_gap());
    send_frame('{11'd520, 16'd555,   16'h0101, 16'h0202, 8'd3},   pick_gap());
    send_frame('{11'd521, 16'd600,   16'hAAAA, 16'h5555, 8'd10},  pick_gap());
    send_frame('{11'd522, 16'd700,   16'h7FFF, 16'h8000, 8'd11},  pick_gap());
    send_frame('{11'd0,   16'd1,     16'h0000, 16'h0000, 8'd0},   pick_gap());
    send_frame('{11'd2047, 16'd2,    16'hFFFF, 16'hFFFF, 8'd255}, pick_gap());

    // chassis ids wrap past 2047, one calibration frame per slot, frames back to back
    drain(SETTLE);
    calm = 1'b1;
    program_regs('{11'd2046, 11'd2, 11'd4, 11'd5, 11'd6, 8'd0});
    send_frame('{11'd2046, 16'd4096,  16'h7FFF, 16'h8000, 8'd0},   0);
    send_frame('{11'd2046, 16'd8193,  16'h8000, 16'h7FFF, 8'd255}, 0);
    send_frame('{11'd2046, 16'd4096,  16'h0001, 16'hFFFF, 8'd1},   0);
    send_frame('{11'd2046, 16'd0,     16'h0002, 16'hFFFE, 8'd2},   0);
    send_frame('{11'd2046, 16'd65535, 16'h0003, 16'hFFFD, 8'd3},   0);
    send_frame('{11'd2046, 16'd0,     16'h0004, 16'hFFFC, 8'd4},   0);
    send_frame('{11'd2047, 16'd0,     16'h1111, 16'h2222, 8'd5},   0);
    send_frame('{11'd1,    16'd12345, 16'h3333, 16'h4444, 8'd6},   0);
    send_frame('{11'd4,    16'd1000,  16'h8000, 16'h7FFF, 8'd255}, 0);
    send_frame('{11'd5,    16'd60000, 16'h8000, 16'h7FFF, 8'd77},  0);
    send_frame('{11'd6,    16'd0,     16'h7FFF, 16'h8000, 8'd255}, 0);
    send_frame('{11'd7,    16'd9,     16'h0000, 16'h0000, 8'd0},   0);
    send_frame('{11'd1024, 16'd9,     16'h0000, 16'h0000, 8'd0},   0);

    run_phase(random_ids(CNT_W'($urandom_range(0, 4))), 160, -1, 1'b0);

    // overlapping ids: chassis wins over launcher and feeder, pitch over yaw
    c = random_ids(8'd2);
    c.launcher_base_id = c.chassis_base_id + ID_W'(2);
    c.feeder_id        = c.chassis_base_id + ID_W'(1);
    c.yaw_id           = c.pitch_id;
    run_phase(c, 100, -1, 1'b0);

    // hammer chassis slot 0 until its frame count saturates
    run_phase('{11'd0, 11'd2045, 11'd100, 11'd2047, 11'd1000, 8'd0}, 300, 0, 1'b1);
    run_phase(random_ids(8'd255), 40, -1, 1'b0);
    run_phase(random_ids(8'd254), 80, 0, 1'b0);
    run_phase(random_ids(CNT_W'($urandom_range(0, 20))), 160, -1, 1'b0);

    drain(SETTLE * 4);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
